// File: rtl/core/lafm_pkg.sv
// ----------------------------------------------------------------------------
// lafm_pkg
// Shared constants for the line-aligned frame mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package lafm_pkg;

    // default coordinate width
    localparam int COORD_BITS_DEF = 16;

    // result magnitude bits and result field width
    localparam int K_BITS = 18;
    localparam int OUT_W  = 18;

    // saturation limits of a result field
    localparam logic [OUT_W-1:0] OUT_POS_MAX = 18'h1FFFF;
    localparam logic [OUT_W-1:0] OUT_NEG_MAX = 18'h20000;

    // output tdata width: two result fields rounded up to whole bytes
    localparam int OUT_DATA_W = ((2 * OUT_W + 7) / 8) * 8;

endpackage

`default_nettype wire

// File: rtl/core/line_aligned_frame_mapper_core.sv
// ----------------------------------------------------------------------------
// line_aligned_frame_mapper_core
// Maps a point into the frame centred on an axis segment's midpoint and
// turned along the segment; exact truncated projections, 18-bit results.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  s       | in        | tdata: point x/y, axis start x/y, axis end x/y
//  m       | out       | tdata: mapped x/y; tuser: degenerate
//
//  One transaction per cycle while the output is not held; stages: 3 front,
//  3 square, 18 quotient-bit stages, 1 output register.
//  The quotient search takes one result bit per stage, one stage per bit.
//  Reset (synchronous, active low) clears all valid bits only.
//  A held output stalls every stage at once; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module line_aligned_frame_mapper_core #(
    parameter int COORD_BITS = lafm_pkg::COORD_BITS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_s_tvalid,
    output logic                                        o_s_tready,
    // px, py, sx, sy, qx, qy from bit 0 up, zero padded
    input  wire logic [((6*COORD_BITS+7)/8)*8-1:0]      i_s_tdata,
    output logic                                        o_m_tvalid,
    input  wire logic                                   i_m_tready,
    // mapped_x, mapped_y from bit 0 up, zero padded
    output logic [lafm_pkg::OUT_DATA_W-1:0]             o_m_tdata,
    // degenerate
    output logic                                        o_m_tuser
);

    localparam int C    = COORD_BITS;
    localparam int KW   = lafm_pkg::K_BITS;
    localparam int OW   = lafm_pkg::OUT_W;
    localparam int MAGW = 2 * C + 2;
    localparam int AW   = (MAGW > 64) ? 64 : MAGW;
    localparam int HW   = (AW + 1) / 2;
    localparam int SQW  = 4 * HW;
    localparam int EW   = 2 * C + 2;
    localparam int MW   = 2 * C + 20;
    localparam int LW   = ((SQW > 2 * C + 40) ? SQW : 2 * C + 40) + 1;

    // global advance: output register free or being drained
    logic en;
    logic r_out_vld;
    assign en         = !r_out_vld || i_m_tready;
    assign o_s_tready = en;

    // front
    logic                  f_vld, f_deg;
    logic signed [2*C+2:0] f_along, f_across;
    logic        [EW-1:0]  f_e2;

    lafm_front #(.C(C)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_vld    (i_s_tvalid),
        .i_px     (i_s_tdata[0*C +: C]),
        .i_py     (i_s_tdata[1*C +: C]),
        .i_sx     (i_s_tdata[2*C +: C]),
        .i_sy     (i_s_tdata[3*C +: C]),
        .i_qx     (i_s_tdata[4*C +: C]),
        .i_qy     (i_s_tdata[5*C +: C]),
        .o_vld    (f_vld),
        .o_along  (f_along),
        .o_across (f_across),
        .o_e2     (f_e2),
        .o_deg    (f_deg)
    );

    // squares of the numerator magnitudes
    logic                  q_vld, q_deg;
    logic [1:0][SQW-1:0]   q_sq;
    logic [1:0]            q_neg, q_ovf;
    logic [EW-1:0]         q_e2;
    logic [1:0][2*C+2:0]   f_num;

    assign f_num[0] = f_along;
    assign f_num[1] = f_across;

    lafm_square #(.C(C), .HW(HW), .SQW(SQW)) u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (f_vld),
        .i_num   (f_num),
        .i_e2    (f_e2),
        .i_deg   (f_deg),
        .o_vld   (q_vld),
        .o_sq    (q_sq),
        .o_neg   (q_neg),
        .o_ovf   (q_ovf),
        .o_e2    (q_e2),
        .o_deg   (q_deg)
    );

    // quotient search chain, most significant bit first
    logic            c_vld [0:KW];
    logic            c_deg [0:KW];
    logic [1:0][LW-1:0] c_r   [0:KW];
    logic [1:0][MW-1:0] c_m   [0:KW];
    logic [1:0][KW-1:0] c_k   [0:KW];
    logic [1:0]         c_neg [0:KW];
    logic [1:0]         c_ovf [0:KW];
    logic [EW-1:0]      c_e2  [0:KW];

    assign c_vld[0]    = q_vld;
    assign c_deg[0]    = q_deg;
    assign c_r[0][0]   = LW'(q_sq[0]);
    assign c_r[0][1]   = LW'(q_sq[1]);
    assign c_m[0]      = '0;
    assign c_k[0]      = '0;
    assign c_neg[0]    = q_neg;
    assign c_ovf[0]    = q_ovf;
    assign c_e2[0]     = q_e2;

    for (genvar i = 0; i < KW; i++) begin : g_root
        lafm_root_stage #(
            .LW(LW), .EW(EW), .MW(MW), .KW(KW), .BIT(KW - 1 - i)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (c_vld[i]),
            .i_r     (c_r[i]),
            .i_m     (c_m[i]),
            .i_k     (c_k[i]),
            .i_neg   (c_neg[i]),
            .i_ovf   (c_ovf[i]),
            .i_e2    (c_e2[i]),
            .i_deg   (c_deg[i]),
            .o_vld   (c_vld[i+1]),
            .o_r     (c_r[i+1]),
            .o_m     (c_m[i+1]),
            .o_k     (c_k[i+1]),
            .o_neg   (c_neg[i+1]),
            .o_ovf   (c_ovf[i+1]),
            .o_e2    (c_e2[i+1]),
            .o_deg   (c_deg[i+1])
        );
    end

    // sign, saturation and degenerate override
    logic [1:0][OW-1:0] n_res;
    logic [1:0][OW-1:0] r_res;
    logic               r_deg;

    always_comb begin
        for (int g = 0; g < 2; g++) begin
            if (c_deg[KW]) begin
                n_res[g] = '0;
            end else if (c_neg[KW][g]) begin
                if (c_ovf[KW][g] || (c_k[KW][g] > KW'(lafm_pkg::OUT_NEG_MAX))) begin
                    n_res[g] = lafm_pkg::OUT_NEG_MAX;
                end else begin
                    n_res[g] = OW'(~c_k[KW][g] + KW'(1));
                end
            end else begin
                if (c_ovf[KW][g] || (c_k[KW][g] > KW'(lafm_pkg::OUT_POS_MAX))) begin
                    n_res[g] = lafm_pkg::OUT_POS_MAX;
                end else begin
                    n_res[g] = OW'(c_k[KW][g]);
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res <= n_res;
            r_deg <= c_deg[KW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= c_vld[KW];
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = lafm_pkg::OUT_DATA_W'({r_res[1], r_res[0]});
    assign o_m_tuser  = r_deg;

`ifndef SYNTHESIS
    // a degenerate axis always gives zero results
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == '0)
        else $error("degenerate result not zero");

    // a held output must block the input side
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("input accepted during output stall");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");
`endif

endmodule

`default_nettype wire

// File: rtl/core/lafm_front.sv
// ----------------------------------------------------------------------------
// lafm_front
// Three stages: differences, products, then the two numerators and |e|^2.
// ----------------------------------------------------------------------------
`default_nettype none

module lafm_front #(
    parameter int C = lafm_pkg::COORD_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_vld,
    input  wire logic signed [C-1:0]   i_px,
    input  wire logic signed [C-1:0]   i_py,
    input  wire logic signed [C-1:0]   i_sx,
    input  wire logic signed [C-1:0]   i_sy,
    input  wire logic signed [C-1:0]   i_qx,
    input  wire logic signed [C-1:0]   i_qy,
    output logic                       o_vld,
    output logic signed [2*C+2:0]      o_along,
    output logic signed [2*C+2:0]      o_across,
    output logic        [2*C+1:0]      o_e2,
    output logic                       o_deg
);

    localparam int PW = 2 * C + 2;

    logic [2:0] r_vld;

    // stage 1: midpoint offsets and axis direction
    logic signed [C:0] sum_x, sum_y, half_x, half_y;
    logic signed [C:0] r_dx, r_dy, r_ex, r_ey;
    logic              r_deg1;

    always_comb begin
        sum_x  = {i_sx[C-1], i_sx} + {i_qx[C-1], i_qx};
        sum_y  = {i_sy[C-1], i_sy} + {i_qy[C-1], i_qy};
        // halve toward zero: add one before the shift when negative
        half_x = $signed(sum_x + {{C{1'b0}}, sum_x[C]}) >>> 1;
        half_y = $signed(sum_y + {{C{1'b0}}, sum_y[C]}) >>> 1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx   <= {i_px[C-1], i_px} - half_x;
            r_dy   <= {i_py[C-1], i_py} - half_y;
            r_ex   <= {i_qx[C-1], i_qx} - {i_sx[C-1], i_sx};
            r_ey   <= {i_qy[C-1], i_qy} - {i_sy[C-1], i_sy};
            r_deg1 <= (i_qx == i_sx) && (i_qy == i_sy);
        end
    end

    // stage 2: cross and dot products, squares
    logic signed [PW-1:0] r_pxe, r_pyy, r_pye, r_pxy, r_sqx, r_sqy;
    logic                 r_deg2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pxe  <= r_dx * r_ex;
            r_pyy  <= r_dy * r_ey;
            r_pye  <= r_dy * r_ex;
            r_pxy  <= r_dx * r_ey;
            r_sqx  <= r_ex * r_ex;
            r_sqy  <= r_ey * r_ey;
            r_deg2 <= r_deg1;
        end
    end

    // stage 3: numerators and squared length
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_along  <= {r_pxe[PW-1], r_pxe} + {r_pyy[PW-1], r_pyy};
            o_across <= {r_pye[PW-1], r_pye} - {r_pxy[PW-1], r_pxy};
            o_e2     <= $unsigned(r_sqx) + $unsigned(r_sqy);
            o_deg    <= r_deg2;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    assign o_vld = r_vld[2];

endmodule

`default_nettype wire

// File: rtl/core/lafm_square.sv
// ----------------------------------------------------------------------------
// lafm_square
// Three stages: magnitude and sign, half-word partial products, square sum.
// ----------------------------------------------------------------------------
`default_nettype none

module lafm_square #(
    parameter int C   = lafm_pkg::COORD_BITS_DEF,
    parameter int HW  = 17,
    parameter int SQW = 68
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_vld,
    input  wire logic [1:0][2*C+2:0]         i_num,
    input  wire logic      [2*C+1:0]         i_e2,
    input  wire logic                        i_deg,
    output logic                             o_vld,
    output logic      [1:0][SQW-1:0]         o_sq,
    output logic      [1:0]                  o_neg,
    output logic      [1:0]                  o_ovf,
    output logic           [2*C+1:0]         o_e2,
    output logic                             o_deg
);

    localparam int NW   = 2 * C + 3;
    localparam int MAGW = 2 * C + 2;
    localparam int AW   = (MAGW > 64) ? 64 : MAGW;

    logic [2:0]                     r_vld;
    logic [1:0]                     r_neg1, r_neg2, r_ovf1, r_ovf2;
    logic [1:0][HW-1:0]             r_ah, r_al;
    logic [1:0][2*HW-1:0]           r_pll, r_plh, r_phh;
    logic [2*C+1:0]                 r_e2a, r_e2b;
    logic                           r_dga, r_dgb;

    for (genvar g = 0; g < 2; g++) begin : g_lane
        logic [NW-1:0]   mag_full;
        logic [AW-1:0]   a_lo;
        logic [2*HW-1:0] a_pad;
        logic            ovf;

        // stage 1: magnitude, split into halves
        assign mag_full = i_num[g][NW-1] ? (~i_num[g] + NW'(1)) : i_num[g];
        assign a_lo     = mag_full[AW-1:0];
        assign a_pad    = (2*HW)'(a_lo);

        if (MAGW > 64) begin : g_ovf
            assign ovf = |mag_full[MAGW-1:64];
        end else begin : g_novf
            assign ovf = 1'b0;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ah[g]   <= a_pad[2*HW-1:HW];
                r_al[g]   <= a_pad[HW-1:0];
                r_neg1[g] <= i_num[g][NW-1];
                r_ovf1[g] <= ovf;
            end
        end

        // stage 2: partial products
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pll[g]  <= r_al[g] * r_al[g];
                r_plh[g]  <= r_al[g] * r_ah[g];
                r_phh[g]  <= r_ah[g] * r_ah[g];
                r_neg2[g] <= r_neg1[g];
                r_ovf2[g] <= r_ovf1[g];
            end
        end

        // stage 3: a^2 = hh<<2H + 2*lh<<H + ll
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                o_sq[g]  <= (SQW'(r_phh[g]) << (2 * HW)) + (SQW'(r_plh[g]) << (HW + 1))
                            + SQW'(r_pll[g]);
                o_neg[g] <= r_neg2[g];
                o_ovf[g] <= r_ovf2[g];
            end
        end
    end

    // side payload delay
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e2a <= i_e2;
            r_dga <= i_deg;
            r_e2b <= r_e2a;
            r_dgb <= r_dga;
            o_e2  <= r_e2b;
            o_deg <= r_dgb;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    assign o_vld = r_vld[2];

endmodule

`default_nettype wire

// File: rtl/core/lafm_root_stage.sv
// ----------------------------------------------------------------------------
// lafm_root_stage
// One bit of the quotient search for both lanes, by shift and subtract.
// Keeps R = a^2 - k^2*e2 and M = k*e2; trying k + 2^b costs
// M<<(b+1) + e2<<(2b).
// ----------------------------------------------------------------------------
`default_nettype none

module lafm_root_stage #(
    parameter int LW  = 73,
    parameter int EW  = 34,
    parameter int MW  = 52,
    parameter int KW  = 18,
    parameter int BIT = 0
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_vld,
    input  wire logic [1:0][LW-1:0]    i_r,
    input  wire logic [1:0][MW-1:0]    i_m,
    input  wire logic [1:0][KW-1:0]    i_k,
    input  wire logic [1:0]            i_neg,
    input  wire logic [1:0]            i_ovf,
    input  wire logic      [EW-1:0]    i_e2,
    input  wire logic                  i_deg,
    output logic                       o_vld,
    output logic      [1:0][LW-1:0]    o_r,
    output logic      [1:0][MW-1:0]    o_m,
    output logic      [1:0][KW-1:0]    o_k,
    output logic      [1:0]            o_neg,
    output logic      [1:0]            o_ovf,
    output logic           [EW-1:0]    o_e2,
    output logic                       o_deg
);

    for (genvar g = 0; g < 2; g++) begin : g_lane
        logic [LW-1:0] trial;
        logic          fit;

        assign trial = (LW'(i_m[g]) << (BIT + 1)) + (LW'(i_e2) << (2 * BIT));
        assign fit   = (trial <= i_r[g]);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                o_r[g]   <= fit ? (i_r[g] - trial) : i_r[g];
                o_m[g]   <= fit ? (i_m[g] + (MW'(i_e2) << BIT)) : i_m[g];
                o_k[g]   <= i_k[g] | (KW'(fit) << BIT);
                o_neg[g] <= i_neg[g];
                o_ovf[g] <= i_ovf[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_e2  <= i_e2;
            o_deg <= i_deg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= i_vld;
        end
    end

endmodule

`default_nettype wire

// File: bench/tb_line_aligned_frame_mapper_core.sv
// ----------------------------------------------------------------------------
// tb_line_aligned_frame_mapper_core
// Self-checking bench for the frame mapper: directed corner points, then
// random points and axes under varying stream pressure, each result checked
// against an exact integer projection computed in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_line_aligned_frame_mapper_core;

    localparam int CW     = 16;
    localparam int IN_W   = ((6 * CW + 7) / 8) * 8;
    localparam int OW     = lafm_pkg::OUT_W;
    localparam int LAT    = 25;
    localparam int LIMIT  = 400000;

    typedef struct packed {
        logic [OW-1:0] mx;
        logic [OW-1:0] my;
        logic          degen;
    } t_mapped;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_s_tvalid;
    logic               o_s_tready;
    logic [IN_W-1:0]    i_s_tdata;   // px, py, sx, sy, qx, qy from bit 0 up
    logic               o_m_tvalid;
    logic               i_m_tready;
    logic [lafm_pkg::OUT_DATA_W-1:0] o_m_tdata;  // mapped_x, mapped_y from bit 0
    logic               o_m_tuser;   // degenerate

    t_mapped expected_q[$];
    int      n_errors;
    int      cycles;
    int      send_idle_pct;
    int      recv_idle_pct;
    int      hold_cycles;

    line_aligned_frame_mapper_core #(.COORD_BITS(CW)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // trunc(num / sqrt(e2)) by bitwise search, saturated to the result width
    function automatic logic [OW-1:0] project_trunc(logic signed [71:0] num,
                                                    logic [71:0] e2);
        logic        neg;
        logic [71:0] mag;
        logic [143:0] sq;
        logic [143:0] trial;
        logic [63:0] k;
        logic [63:0] c;
        neg = num[71];
        mag = neg ? -num : num;
        sq  = mag * mag;
        k   = 0;
        for (int b = 17; b >= 0; b--) begin
            c = k | (64'd1 << b);
            trial = e2 * (c * c);
            if (trial <= sq) k = c;
        end
        if (neg) begin
            if (k > 131072) k = 131072;
            return OW'(-k);
        end
        if (k > 131071) k = 131071;
        return OW'(k);
    endfunction

    function automatic t_mapped map_point(logic [IN_W-1:0] d);
        logic signed [71:0] px, py, sx, sy, qx, qy, ex, ey, dx, dy;
        logic [71:0] e2;
        t_mapped r;
        px = $signed(d[0*CW +: CW]);
        py = $signed(d[1*CW +: CW]);
        sx = $signed(d[2*CW +: CW]);
        sy = $signed(d[3*CW +: CW]);
        qx = $signed(d[4*CW +: CW]);
        qy = $signed(d[5*CW +: CW]);
        ex = qx - sx;
        ey = qy - sy;
        // midpoint truncated toward zero
        dx = px - (sx + qx) / 2;
        dy = py - (sy + qy) / 2;
        r = '0;
        if (ex == 0 && ey == 0) begin
            r.degen = 1'b1;
            return r;
        end
        e2 = ex * ex + ey * ey;
        r.mx = project_trunc(dx * ex + dy * ey, e2);
        r.my = project_trunc(dy * ex - dx * ey, e2);
        return r;
    endfunction

    // one item: wait for acceptance, queue its expected result
    task automatic send_point(input logic [15:0] px, py, sx, sy, qx, qy);
        logic [IN_W-1:0] d;
        d = '0;
        d[6*CW-1:0] = {qy, qx, sy, sx, py, px};
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        expected_q.push_back(map_point(d));
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(int'($urandom_range(16)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        send_point(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000);
        send_point(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
        send_point(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
        send_point(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
        send_point(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        // start equals end
        send_point(16'h1234, 16'hABCD, 16'h0005, 16'hFFFB, 16'h0005, 16'hFFFB);
        send_point(16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        // odd coordinate sums, negative midpoint truncation
        send_point(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFE, 16'hFFFE, 16'hFFFF);
        send_point(16'h0003, 16'hFFFD, 16'h0001, 16'h0000, 16'h0002, 16'h0000);
        // near-parallel axis
        send_point(16'h7000, 16'h0100, 16'h8000, 16'h0000, 16'h7FFF, 16'h0001);
        send_point(16'h9000, 16'h0100, 16'h0000, 16'h8000, 16'h0001, 16'h7FFF);
        send_point(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
        send_point(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA);
        drain_results();
    endtask

    task automatic test_random(input int count);
        logic [15:0] sx, sy;
        for (int i = 0; i < count; i++) begin
            sx = rand_coord();
            sy = rand_coord();
            if ($urandom_range(19) == 0)
                send_point(rand_coord(), rand_coord(), sx, sy, sx, sy);
            else
                send_point(rand_coord(), rand_coord(), sx, sy,
                           rand_coord(), rand_coord());
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 200;
        send_idle_pct = 0;
        test_random(80);
        drain_results();
    endtask

    // receiver: random ready, plus a counted long hold when asked
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_m_tready  <= 1'b0;
        end else begin
            i_m_tready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_mapped exp_r;
        t_mapped got;
        cycles <= cycles + 1;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.mx = o_m_tdata[0 +: OW];
            got.my = o_m_tdata[OW +: OW];
            got.degen = o_m_tuser;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                n_errors++;
            end else begin
                exp_r = expected_q.pop_front();
                if (got.mx !== exp_r.mx) begin
                    $display("%0t: mapped_x exp %h got %h", $time, exp_r.mx, got.mx);
                    n_errors++;
                end
                if (got.my !== exp_r.my) begin
                    $display("%0t: mapped_y exp %h got %h", $time, exp_r.my, got.my);
                    n_errors++;
                end
                if (got.degen !== exp_r.degen) begin
                    $display("%0t: degenerate exp %b got %b", $time, exp_r.degen,
                             got.degen);
                    n_errors++;
                end
            end
        end
    end

    // run-length guard
    always @(posedge i_clk) begin
        if (cycles > LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_m_tready    = 1'b0;
        n_errors      = 0;
        cycles        = 0;
        hold_cycles   = 0;
        send_idle_pct = 26;
        recv_idle_pct = 53;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(450);
        // sender pauses until everything is back
        drain_results();
        send_idle_pct = 53;
        recv_idle_pct = 26;
        test_random(450);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(400);
        test_backpressure();
        repeat (LAT + 10) @(posedge i_clk);
        if (n_errors == 0 && expected_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
